// ===== src/sdaf_pkg.sv =====
`timescale 1ns / 1ps

package sdaf_pkg;

  localparam int unsigned NumBits   = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CntW      = $clog2(NumBits);
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned CharW     = 8;

  // Lowest integer digit in thousandths mode; digits below it are the fraction.
  localparam logic [IdxW-1:0] FracTop = IdxW'(3);

  localparam logic [CharW-1:0] AsciiZero = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharPoint = 8'h2E;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StStart,
    StSign,
    StDigit,
    StPoint
  } state_e;

  typedef enum logic [1:0] {
    SelMinus,
    SelDigit,
    SelPoint
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      shift;
    logic      dig_init;
    logic      dig_dec;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic neg;
    logic frac;
    logic dig_zero;
    logic dig_three;
    logic out_free;
  } stat_t;

endpackage

// ===== src/sdaf_datapath.sv =====
`timescale 1ns / 1ps

module sdaf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [sdaf_pkg::NumBits-1:0] in_number_i,
  input  logic                               in_frac_i,
  input  sdaf_pkg::cmd_t                     cmd_i,
  output sdaf_pkg::stat_t                    stat_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [sdaf_pkg::CharW-1:0]         out_char_o,
  output logic                               out_last_o
);
  import sdaf_pkg::*;

  localparam int unsigned BcdW = NumDigits * DigitW;

  logic [NumBits-1:0]                bin_q, bin_d;
  logic [NumDigits-1:0][DigitW-1:0]  bcd_q, bcd_d, adj;
  logic [BcdW-1:0]                   adj_flat;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic [IdxW-1:0]                   dig_q, dig_d, top;
  logic                              neg_q, frac_q;
  logic                              out_valid_q, out_valid_d;
  logic [CharW-1:0]                  out_char_q, out_char_d;
  logic                              out_last_q;
  logic [DigitW-1:0]                 cur_digit;
  logic [NumBits-1:0]                mag;

  assign mag = in_number_i[NumBits-1] ? (~in_number_i + 1'b1) : in_number_i;

  // Double dabble: correct every digit of five or more before each shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (bcd_q[i] >= DigitW'(5)) ? bcd_q[i] + DigitW'(3) : bcd_q[i];
    end
  end

  assign adj_flat = adj;

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      bin_d = mag;
      bcd_d = '0;
      cnt_d = '0;
    end else if (cmd_i.shift) begin
      bin_d = {bin_q[NumBits-2:0], 1'b0};
      bcd_d = {adj_flat[BcdW-2:0], bin_q[NumBits-1]};
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Highest nonzero digit; at least the units digit of the integer part.
  always_comb begin
    top = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (bcd_q[i] != '0) top = IdxW'(i);
    end
    if (frac_q && top < FracTop) top = FracTop;
  end

  always_comb begin
    dig_d = dig_q;
    if (cmd_i.dig_init) begin
      dig_d = top;
    end else if (cmd_i.dig_dec) begin
      dig_d = dig_q - 1'b1;
    end
  end

  assign cur_digit = bcd_q[dig_q];

  always_comb begin
    unique case (cmd_i.sel)
      SelMinus: out_char_d = CharMinus;
      SelPoint: out_char_d = CharPoint;
      SelDigit: out_char_d = AsciiZero + {{(CharW-DigitW){1'b0}}, cur_digit};
      default:  out_char_d = AsciiZero;
    endcase
  end

  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    dig_q <= dig_d;
    if (cmd_i.load) begin
      neg_q  <= in_number_i[NumBits-1];
      frac_q <= in_frac_i;
    end
    if (cmd_i.emit) begin
      out_char_q <= out_char_d;
      out_last_q <= cmd_i.last;
    end
  end

  assign stat_o.conv_last = (cnt_q == CntW'(NumBits - 1));
  assign stat_o.neg       = neg_q;
  assign stat_o.frac      = frac_q;
  assign stat_o.dig_zero  = (dig_q == '0);
  assign stat_o.dig_three = (dig_q == FracTop);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  // The first digit printed is nonzero unless it is the forced units digit.
  a_top_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dig_init |=> (cur_digit != '0) || (dig_q == '0) || (frac_q && dig_q == FracTop))
    else $error("leading digit is a zero that should have been stripped");

endmodule

// ===== src/sdaf_ctrl.sv =====
`timescale 1ns / 1ps

module sdaf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sdaf_pkg::stat_t stat_i,
  output sdaf_pkg::cmd_t  cmd_o
);
  import sdaf_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StConv;
      StConv:  if (stat_i.conv_last) state_d = StStart;
      StStart: state_d = stat_i.neg ? StSign : StDigit;
      StSign:  if (stat_i.out_free) state_d = StDigit;
      StDigit: begin
        if (stat_i.out_free) begin
          priority if (stat_i.dig_zero) state_d = StIdle;
          else if (stat_i.frac && stat_i.dig_three) state_d = StPoint;
          else state_d = StDigit;
        end
      end
      StPoint: if (stat_i.out_free) state_d = StDigit;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SelDigit;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StConv:  cmd_o.shift = 1'b1;
      StStart: cmd_o.dig_init = 1'b1;
      StSign: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = SelMinus;
      end
      StDigit: begin
        cmd_o.emit    = stat_i.out_free;
        cmd_o.sel     = SelDigit;
        cmd_o.last    = stat_i.dig_zero;
        cmd_o.dig_dec = stat_i.out_free && !stat_i.dig_zero;
      end
      StPoint: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = SelPoint;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == StIdle))
    else $error("word marked last but the number is not finished");

  // The point is entered only straight after the lowest integer digit in thousandths mode.
  a_point_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StPoint) && ($past(state_q) != StPoint))
      |-> $past(stat_i.frac && stat_i.dig_three))
    else $error("decimal point outside thousandths mode or at the wrong digit");

  a_last_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.last |-> (state_q == StDigit && stat_i.dig_zero))
    else $error("last marker on a word other than the units digit");

endmodule

// ===== src/signed_decimal_ascii_formatter_unit.sv =====
`timescale 1ns / 1ps
// An accepted word is loaded, converted in the 32 shift steps of the bit-serial
// binary to decimal converter and set up before the first character is issued.
// Throughput: one character per cycle while the output is taken; a new number is
// accepted only after the last character of the current one has been issued.
// Reset is asynchronous and active low; it clears the controller and the output valid.
module signed_decimal_ascii_formatter_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic signed [31:0]       s_axis_tdata_i,  // [31:0] number
  input  logic                     s_axis_tuser_i,  // [0] thousandths
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [7:0]               m_axis_tdata_o,  // [7:0] character
  output logic                     m_axis_tlast_o
);
  import sdaf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sdaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sdaf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_number_i (s_axis_tdata_i),
    .in_frac_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== test/decimal_text_checker.sv =====
`timescale 1ns / 1ps

module decimal_text_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [31:0]                in_number_i,
  input  logic                       in_thousandths_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [sdaf_pkg::CharW-1:0] out_char_i,
  input  logic                       out_last_i,
  output int                         err_count_o,
  output int                         pending_o
);
  import sdaf_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  text_char_t expected_text[$];
  int         err_count = 0;
  int         chars_seen = 0;

  assign err_count_o = err_count;

  task automatic report_mismatch(input string what);
    $display("checker: char %0d: %s", chars_seen, what);
    err_count++;
  endtask

  // Appends the expected characters of one number, the final one marked last.
  function automatic void queue_decimal_text(input logic [31:0] raw, input logic frac_mode);
    logic [31:0]      mag;
    logic [31:0]      whole;
    logic [31:0]      frac;
    logic [3:0]       digs[10];
    logic [CharW-1:0] text[$];
    int               n;
    text_char_t       c;

    mag = raw[31] ? (~raw + 32'd1) : raw;
    if (raw[31]) begin
      text.push_back(CharMinus);
    end
    whole = frac_mode ? mag / 32'd1000 : mag;
    frac  = mag % 32'd1000;
    n = 0;
    do begin
      digs[n] = 4'(whole % 32'd10);
      whole   = whole / 32'd10;
      n++;
    end while (whole != 0);
    for (int i = n - 1; i >= 0; i--) begin
      text.push_back(AsciiZero + CharW'(digs[i]));
    end
    if (frac_mode) begin
      text.push_back(CharPoint);
      text.push_back(AsciiZero + CharW'(frac / 32'd100));
      text.push_back(AsciiZero + CharW'((frac / 32'd10) % 32'd10));
      text.push_back(AsciiZero + CharW'(frac % 32'd10));
    end
    foreach (text[i]) begin
      c.ch   = text[i];
      c.last = (i == text.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        queue_decimal_text(in_number_i, in_thousandths_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b", out_char_i, out_last_i));
        end else begin
          want = expected_text.pop_front();
          if (out_char_i !== want.ch) begin
            report_mismatch($sformatf("character %h, wanted %h", out_char_i, want.ch));
          end
          if (out_last_i !== want.last) begin
            report_mismatch($sformatf("last %b, wanted %b", out_last_i, want.last));
          end
        end
        chars_seen++;
      end
    end
    pending_o <= expected_text.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int StallLimit = 5000;
  localparam int NumRandom  = 98;

  logic               clk;
  logic               rst_n;
  logic               s_tvalid;
  logic               s_tready;
  logic signed [31:0] s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [7:0]         m_tdata;
  logic               m_tlast;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;
  int err_count;
  int pending_chars;

  signed_decimal_ascii_formatter_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  decimal_text_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (s_tvalid),
    .in_ready_i       (s_tready),
    .in_number_i      (s_tdata),
    .in_thousandths_i (s_tuser),
    .out_valid_i      (m_tvalid),
    .out_ready_i      (m_tready),
    .out_char_i       (m_tdata),
    .out_last_i       (m_tlast),
    .err_count_o      (err_count),
    .pending_o        (pending_chars)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Counts cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one word, with random gaps before it, and returns at its accepting edge.
  task automatic push_number(input logic [31:0] num, input logic frac_mode);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= num;
    s_tuser  <= frac_mode;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] random_number();
    logic [31:0] v;
    logic [31:0] p;
    case ($urandom_range(5))
      0, 1: v = $urandom();
      2: v = 32'($urandom_range(2999));
      3: v = 32'd0 - 32'($urandom_range(2999));
      4: begin
        p = 32'd1;
        repeat ($urandom_range(9)) p = p * 32'd10;
        v = p + 32'($urandom_range(2)) - 32'd1;
        if ($urandom_range(1) == 1) v = 32'd0 - v;
      end
      default: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0001;
          default: v = 32'hffff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 69;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero, the extremes, small fractions and digit-count boundaries.
    push_number(32'd0, 1'b0);
    push_number(32'd0, 1'b1);
    push_number(32'h8000_0000, 1'b0);
    push_number(32'h8000_0000, 1'b1);
    push_number(32'h7fff_ffff, 1'b0);
    push_number(32'h7fff_ffff, 1'b1);
    push_number(32'h8000_0001, 1'b0);
    push_number(32'hffff_ffff, 1'b0);
    push_number(32'hffff_ffff, 1'b1);
    push_number(-32'sd5, 1'b1);
    push_number(32'd5, 1'b1);
    push_number(32'd999, 1'b1);
    push_number(32'd1000, 1'b1);
    push_number(-32'sd1000, 1'b1);
    push_number(-32'sd999, 1'b1);
    push_number(32'd9, 1'b0);
    push_number(32'd10, 1'b0);
    push_number(-32'sd7, 1'b0);
    push_number(32'd123456, 1'b1);
    push_number(32'd1000000000, 1'b0);
    push_number(-32'sd999999999, 1'b0);
    push_number(32'd1000000000, 1'b1);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 13;
      end else if (i == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      push_number(random_number(), 1'($urandom_range(1)));
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_chars != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sdaf_pkg.sv
src/sdaf_datapath.sv
src/sdaf_ctrl.sv
src/signed_decimal_ascii_formatter_unit.sv
test/decimal_text_checker.sv
test/tb.sv
